@@ sv/rc5ir_pkg.sv @@
// ----------------------------------------------------------------------------
// rc5ir_pkg: shared types and constants of the RC-5 frame transmitter
// Function codes, register indexes, frame constants and the structs that
// travel between the configuration block, the engine and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc5ir_pkg;

  // Default width of the half-bit timer
  localparam int TIMER_BITS_DEF = 16;

  // Frame layout
  localparam int FRAME_BITS = 14;
  localparam int BITS_W     = 4;
  localparam int ADDR_W     = 5;
  localparam int CMD_W      = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int HALF_REG_W = 16;
  localparam int CARR_W     = 8;

  // Reset values of the timing registers
  localparam logic [HALF_REG_W-1:0] SPACE_TICKS_RST = 16'd864;
  localparam logic [HALF_REG_W-1:0] MARK_TICKS_RST  = 16'd760;
  localparam logic [CARR_W-1:0]     CARR_HIGH_RST   = 8'd10;
  localparam logic [CARR_W-1:0]     CARR_LOW_RST    = 8'd10;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_START     = 2'd1,
    FUNC_SET_LEVEL = 2'd2
  } func_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACE_TICKS = 4'd0,
    REG_MARK_TICKS  = 4'd1,
    REG_CARR_HIGH   = 4'd2,
    REG_CARR_LOW    = 4'd3
  } reg_idx_e;

  // Timing settings seen by the engine
  typedef struct packed {
    logic [HALF_REG_W-1:0] space_ticks;
    logic [HALF_REG_W-1:0] mark_ticks;
    logic [CARR_W-1:0]     carr_high;
    logic [CARR_W-1:0]     carr_low;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } result_t;

  // Carrier phase length: zero counts as one tick
  function automatic logic [CARR_W-1:0] carr_dur(input logic [CARR_W-1:0] v);
    carr_dur = (v == '0) ? {{(CARR_W-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

@@ sv/rc5ir_cfg.sv @@
// ----------------------------------------------------------------------------
// rc5ir_cfg: timing register file
// Holds the four timing registers and takes writes from the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc5ir_cfg import rc5ir_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Always take a write transaction
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Decode the register index; drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SPACE_TICKS: cfg_d.space_ticks = cfg_data_i[HALF_REG_W-1:0];
        REG_MARK_TICKS:  cfg_d.mark_ticks  = cfg_data_i[HALF_REG_W-1:0];
        REG_CARR_HIGH:   cfg_d.carr_high   = cfg_data_i[CARR_W-1:0];
        REG_CARR_LOW:    cfg_d.carr_low    = cfg_data_i[CARR_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.space_ticks <= SPACE_TICKS_RST;
      cfg_q.mark_ticks  <= MARK_TICKS_RST;
      cfg_q.carr_high   <= CARR_HIGH_RST;
      cfg_q.carr_low    <= CARR_LOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/rc5ir_engine.sv @@
// ----------------------------------------------------------------------------
// rc5ir_engine: frame state and single-pass next-state logic
// Holds the frame shifter, half-bit and carrier timers and computes the new
// state and the result of one transaction combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc5ir_engine import rc5ir_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [1:0]        func_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic              level_i,
  input  cfg_t              cfg_i,
  output result_t           res_o
);

  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [BITS_W-1:0]     bits_q, bits_d;
  logic                  sh_q, sh_d;
  logic [TIMER_BITS-1:0] ht_q, ht_d;
  logic [CARR_W-1:0]     ct_q, ct_d;
  logic                  cp_q, cp_d;
  logic                  tog_q, tog_d;
  logic                  send_q, send_d;
  logic                  idle_q, idle_d;

  logic [TIMER_BITS-1:0] mark_dur, space_dur;
  logic [CARR_W-1:0]     high_dur, low_dur;
  logic                  mark_q;
  logic                  mark_d;

  // Half-bit length: mask to the timer width, zero counts as one tick
  function automatic logic [TIMER_BITS-1:0] half_dur(input logic [HALF_REG_W-1:0] v);
    logic [TIMER_BITS+HALF_REG_W-1:0] w;
    logic [TIMER_BITS-1:0]            t;
    w = {{TIMER_BITS{1'b0}}, v};
    t = w[TIMER_BITS-1:0];
    half_dur = (t == '0) ? {{(TIMER_BITS-1){1'b0}}, 1'b1} : t;
  endfunction

  assign mark_dur  = half_dur(cfg_i.mark_ticks);
  assign space_dur = half_dur(cfg_i.space_ticks);
  assign high_dur  = carr_dur(cfg_i.carr_high);
  assign low_dur   = carr_dur(cfg_i.carr_low);

  // A burst half is the first half of a zero or the second half of a one
  assign mark_q = sh_q ? shift_q[FRAME_BITS-1] : ~shift_q[FRAME_BITS-1];

  // Advance the state for one transaction
  always_comb begin
    logic                  do_load;
    logic                  load_mark;
    logic [CARR_W-1:0]     ct_n;
    logic [TIMER_BITS-1:0] ht_n;
    do_load   = 1'b0;
    load_mark = 1'b0;
    ct_n      = ct_q;
    ht_n      = ht_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    sh_d      = sh_q;
    ht_d      = ht_q;
    ct_d      = ct_q;
    cp_d      = cp_q;
    tog_d     = tog_q;
    send_d    = send_q;
    idle_d    = idle_q;
    res_o.accepted   = 1'b0;
    res_o.frame_done = 1'b0;

    case (func_e'(func_i))
      FUNC_TICK: begin
        if (send_q) begin
          // Carrier runs only during a burst half
          if (mark_q) begin
            ct_n = (ct_q != '0) ? ct_q - 1'b1 : ct_q;
            if (ct_n == '0) begin
              cp_d = ~cp_q;
              ct_n = cp_d ? high_dur : low_dur;
            end
            ct_d = ct_n;
          end
          ht_n = (ht_q != '0) ? ht_q - 1'b1 : ht_q;
          ht_d = ht_n;
          if (ht_n == '0) begin
            if (!sh_q) begin
              sh_d      = 1'b1;
              do_load   = 1'b1;
              load_mark = shift_q[FRAME_BITS-1];
            end else begin
              sh_d    = 1'b0;
              shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
              bits_d  = bits_q - 1'b1;
              if (bits_d == '0) begin
                send_d           = 1'b0;
                res_o.frame_done = 1'b1;
                ht_d             = '0;
                ct_d             = '0;
                cp_d             = 1'b0;
              end else begin
                do_load   = 1'b1;
                load_mark = ~shift_q[FRAME_BITS-2];
              end
            end
          end
        end
      end
      FUNC_START: begin
        if (!send_q) begin
          tog_d          = ~tog_q;
          shift_d        = {2'b11, tog_d, address_i, command_i};
          bits_d         = BITS_W'(FRAME_BITS);
          sh_d           = 1'b0;
          send_d         = 1'b1;
          do_load        = 1'b1;
          load_mark      = 1'b0;
          res_o.accepted = 1'b1;
        end
      end
      FUNC_SET_LEVEL: begin
        if (!send_q) begin
          idle_d         = level_i;
          res_o.accepted = 1'b1;
        end
      end
      default: begin
        res_o.accepted = 1'b0;
      end
    endcase

    // Load the timers for a new half-bit
    if (do_load) begin
      if (load_mark) begin
        ht_d = mark_dur;
        cp_d = 1'b1;
        ct_d = high_dur;
      end else begin
        ht_d = space_dur;
        cp_d = 1'b0;
        ct_d = '0;
      end
    end

    // Pin level after this transaction
    mark_d         = sh_d ? shift_d[FRAME_BITS-1] : ~shift_d[FRAME_BITS-1];
    res_o.ir_level = send_d ? (mark_d & cp_d) : idle_d;
    res_o.busy_res = send_d;
  end

  // Commit the state on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bits_q  <= '0;
      sh_q    <= 1'b0;
      ht_q    <= '0;
      ct_q    <= '0;
      cp_q    <= 1'b0;
      tog_q   <= 1'b0;
      send_q  <= 1'b0;
      idle_q  <= 1'b0;
    end else if (in_fire_i) begin
      shift_q <= shift_d;
      bits_q  <= bits_d;
      sh_q    <= sh_d;
      ht_q    <= ht_d;
      ct_q    <= ct_d;
      cp_q    <= cp_d;
      tog_q   <= tog_d;
      send_q  <= send_d;
      idle_q  <= idle_d;
    end
  end

  // Timers are cleared whenever no frame is on the air
  a_idle_timers_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !send_q |-> (ht_q == '0) && (ct_q == '0) && !cp_q)
    else $error("timers not cleared while idle");

  // A frame in flight always has bits left and a running half timer
  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_q |-> (bits_q != '0) && (ht_q != '0))
    else $error("frame in flight with empty counters");

  // Frame end comes only from a tick of the last half and leaves the engine idle
  a_done_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && res_o.frame_done) |=> !send_q && (bits_q == '0))
    else $error("frame end did not return to idle");

endmodule

@@ sv/rc5ir_out_reg.sv @@
// ----------------------------------------------------------------------------
// rc5ir_out_reg: result register
// Holds one result transaction until the consumer takes it, and opens the
// input side whenever the register is empty or being emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc5ir_out_reg import rc5ir_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign in_ready_o = ~valid_q | out_ready_i;
  assign load       = in_valid_i & in_ready_o;

  // Fill on load, drain when taken
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/rc5_ir_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// rc5_ir_frame_transmitter: RC-5 infrared frame transmitter
// Builds 14-bit RC-5 frames and drives them Manchester coded with a carrier.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, tick, start or set-level,
// while in_ready_o is high, and returns exactly one result for each, in the
// cycle after acceptance, from a single result register. The whole state
// update for a transaction is done combinationally, so ticks may arrive back
// to back; in_ready_o is low only while the result register holds a result
// that has not been taken. The pin level reported is the level after the
// transaction. Timing registers are written through the config channel, which
// is always ready; write them only while no frame is in flight.
`timescale 1ns / 1ps

module rc5_ir_frame_transmitter import rc5ir_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  logic [CMD_W-1:0]      command_i,
  input  logic                  level_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ir_level_o,
  output logic                  busy_res_o,
  output logic                  accepted_o,
  output logic                  frame_done_o
);

  cfg_t    cfg;
  result_t res_next;
  result_t res_out;
  logic    in_fire;

  assign in_fire = in_valid_i & in_ready_o;

  rc5ir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rc5ir_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .func_i    (func_i),
    .address_i (address_i),
    .command_i (command_i),
    .level_i   (level_i),
    .cfg_i     (cfg),
    .res_o     (res_next)
  );

  rc5ir_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (res_next),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign ir_level_o   = res_out.ir_level;
  assign busy_res_o   = res_out.busy_res;
  assign accepted_o   = res_out.accepted;
  assign frame_done_o = res_out.frame_done;

endmodule
